// File: rtl/core/assert_macros.svh
// Assertion macros shared by the sequencer RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked check that is switched off while reset is asserted.
`define MPTS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that must also hold while reset is asserted.
`define MPTS_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPTS_ASSERT(label, clk, rst_n, prop, msg)
`define MPTS_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: rtl/core/mpts_pkg.sv
package mpts_pkg;

  // Memory geometry.
  localparam int ADDR_BITS  = 20;
  localparam int DATA_BITS  = 32;
  localparam int END_BITS   = ADDR_BITS + 1;
  localparam int BIT_W      = $clog2(DATA_BITS);
  localparam int PASS_W     = 6;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = END_BITS;

  // Pass counts of the two phases.
  localparam logic [PASS_W-1:0] UNIFORM_PASSES    = PASS_W'(DATA_BITS);
  localparam logic [PASS_W-1:0] WALK_ONES_PASSES  = PASS_W'(DATA_BITS + 1);
  localparam logic [PASS_W-1:0] ROTATING_PASSES   = PASS_W'(DATA_BITS);

  // Request mode codes.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_WORD   = 2'd0,
    CFG_END_WORD     = 2'd1,
    CFG_PATTERN_KIND = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PAT_WALK_ONES    = 2'd0,
    PAT_WALK_ZEROS   = 2'd1,
    PAT_STREAM_ONES  = 2'd2,
    PAT_STREAM_ZEROS = 2'd3
  } pattern_e;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_WRITE = 2'd1,
    ACC_READ  = 2'd2,
    ACC_DONE  = 2'd3
  } access_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_P1_WRITE = 3'd1,
    ST_P1_READ  = 3'd2,
    ST_P2_WRITE = 3'd3,
    ST_P2_READ  = 3'd4,
    ST_DONE     = 3'd5,
    ST_REFUSED  = 3'd6
  } stage_e;

  // Configuration register contents.
  typedef struct packed {
    logic [ADDR_BITS-1:0] first_word;
    logic [END_BITS-1:0]  end_word;
    pattern_e             pattern_kind;
  } cfg_t;

  // One result item.
  typedef struct packed {
    access_e              access_kind;
    logic [ADDR_BITS-1:0] access_word;
    logic [DATA_BITS-1:0] write_word;
    logic                 mismatch;
    logic                 fail_seen;
    logic [ADDR_BITS-1:0] last_fail_word;
    logic                 bad_range;
  } rsp_t;

endpackage

// File: rtl/core/mpts_if.sv
// Request channel: one step command and the read data of the previous read.
interface mpts_req_if import mpts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [DATA_BITS-1:0] read_data;

  modport source (output valid, output mode, output read_data, input ready);
  modport sink   (input valid, input mode, input read_data, output ready);
endinterface

// Result channel: the memory access for this step and the test status.
interface mpts_rsp_if import mpts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           access_kind;
  logic [ADDR_BITS-1:0] access_word;
  logic [DATA_BITS-1:0] write_word;
  logic                 mismatch;
  logic                 fail_seen;
  logic [ADDR_BITS-1:0] last_fail_word;
  logic                 bad_range;

  modport source (output valid, output access_kind, output access_word, output write_word,
                  output mismatch, output fail_seen, output last_fail_word,
                  output bad_range, input ready);
  modport sink   (input valid, input access_kind, input access_word, input write_word,
                  input mismatch, input fail_seen, input last_fail_word,
                  input bad_range, output ready);
endinterface

// File: rtl/core/mpts_cfg_regs.sv
module mpts_cfg_regs import mpts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  // Register write decode; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_word   <= '0;
      cfg_q.end_word     <= '0;
      cfg_q.pattern_kind <= PAT_WALK_ONES;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FIRST_WORD:   cfg_q.first_word   <= cfg_wdata_i[ADDR_BITS-1:0];
        CFG_END_WORD:     cfg_q.end_word     <= cfg_wdata_i;
        CFG_PATTERN_KIND: cfg_q.pattern_kind <= pattern_e'(cfg_wdata_i[1:0]);
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/mpts_pattern_gen.sv
module mpts_pattern_gen import mpts_pkg::*; (
  input  logic [BIT_W-1:0]     bit_idx_i,
  input  pattern_e             kind_i,
  output logic [DATA_BITS-1:0] pattern_o
);

  logic [DATA_BITS-1:0] one_hot;
  logic [DATA_BITS-1:0] low_fill;

  // Single bit at the index, and every bit from zero up to the index.
  always_comb begin
    for (int i = 0; i < DATA_BITS; i++) begin
      one_hot[i]  = (BIT_W'(i) == bit_idx_i);
      low_fill[i] = (BIT_W'(i) <= bit_idx_i);
    end
  end

  // Shape the word for the selected pattern kind.
  always_comb begin
    case (kind_i)
      PAT_WALK_ONES:   pattern_o = one_hot;
      PAT_WALK_ZEROS:  pattern_o = ~one_hot;
      PAT_STREAM_ONES: pattern_o = low_fill;
      default:         pattern_o = ~low_fill;
    endcase
  end

endmodule

// File: rtl/core/mpts_engine.sv
`include "assert_macros.svh"

module mpts_engine import mpts_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 mode_i,
  input  logic [DATA_BITS-1:0] read_data_i,
  input  cfg_t                 cfg_i,
  input  logic [DATA_BITS-1:0] pattern_i,
  output logic [BIT_W-1:0]     bit_idx_o,
  output rsp_t                 rsp_o
);

  stage_e               stage_q, stage_d;
  logic [PASS_W-1:0]    pass_q, pass_d;
  logic [ADDR_BITS-1:0] cursor_q, cursor_d;
  logic                 rd_pend_q, rd_pend_d;
  logic [DATA_BITS-1:0] expect_q, expect_d;
  logic                 fail_q, fail_d;
  logic [ADDR_BITS-1:0] fail_word_q, fail_word_d;
  logic [ADDR_BITS-1:0] pend_word_q, pend_word_d;

  logic                 phase_two;
  logic                 last_word;
  logic                 mis;
  logic [BIT_W-1:0]     word_ofs;
  logic [ADDR_BITS-1:0] cursor_inc;
  logic [PASS_W-1:0]    pass_inc;
  logic [PASS_W-1:0]    rot_passes;

  // Datapath terms shared by the next-state and output logic.
  assign phase_two  = (stage_q == ST_P2_WRITE) || (stage_q == ST_P2_READ);
  assign word_ofs   = phase_two ? (BIT_W'(cursor_q) - BIT_W'(cfg_i.first_word)) : '0;
  assign bit_idx_o  = pass_q[BIT_W-1:0] + word_ofs;
  assign last_word  = ({1'b0, cursor_q} + END_BITS'(1)) >= cfg_i.end_word;
  assign cursor_inc = cursor_q + ADDR_BITS'(1);
  assign pass_inc   = pass_q + PASS_W'(1);
  assign rot_passes = (cfg_i.pattern_kind == PAT_WALK_ONES) ? WALK_ONES_PASSES
                                                            : ROTATING_PASSES;
  assign mis        = (mode_i == MODE_STEP) && rd_pend_q && (read_data_i != expect_q);

  // Next state of the sequencer for one accepted request.
  always_comb begin
    stage_d     = stage_q;
    pass_d      = pass_q;
    cursor_d    = cursor_q;
    rd_pend_d   = rd_pend_q;
    expect_d    = expect_q;
    fail_d      = fail_q;
    fail_word_d = fail_word_q;
    pend_word_d = pend_word_q;
    if (step_i) begin
      if (mode_i == MODE_START) begin
        pass_d      = '0;
        cursor_d    = cfg_i.first_word;
        rd_pend_d   = 1'b0;
        expect_d    = '0;
        fail_d      = 1'b0;
        fail_word_d = '0;
        pend_word_d = '0;
        if ({1'b0, cfg_i.first_word} > cfg_i.end_word) begin
          stage_d = ST_REFUSED;
        end else if ({1'b0, cfg_i.first_word} == cfg_i.end_word) begin
          stage_d = ST_DONE;
        end else begin
          stage_d = ST_P1_WRITE;
        end
      end else begin
        // Check the read issued in the previous step.
        if (rd_pend_q) begin
          rd_pend_d = 1'b0;
          if (mis) begin
            fail_d      = 1'b1;
            fail_word_d = pend_word_q;
          end
        end
        unique case (stage_q)
          ST_P1_WRITE, ST_P2_WRITE: begin
            if (last_word) begin
              cursor_d = cfg_i.first_word;
              stage_d  = phase_two ? ST_P2_READ : ST_P1_READ;
            end else begin
              cursor_d = cursor_inc;
            end
          end
          ST_P1_READ, ST_P2_READ: begin
            rd_pend_d   = 1'b1;
            expect_d    = pattern_i;
            pend_word_d = cursor_q;
            if (last_word) begin
              cursor_d = cfg_i.first_word;
              if (!phase_two) begin
                if (pass_inc >= UNIFORM_PASSES) begin
                  pass_d  = '0;
                  stage_d = ST_P2_WRITE;
                end else begin
                  pass_d  = pass_inc;
                  stage_d = ST_P1_WRITE;
                end
              end else if (pass_inc >= rot_passes) begin
                pass_d  = '0;
                stage_d = ST_DONE;
              end else begin
                pass_d  = pass_inc;
                stage_d = ST_P2_WRITE;
              end
            end else begin
              cursor_d = cursor_inc;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result item of this request.
  always_comb begin
    rsp_o             = '0;
    rsp_o.access_kind = ACC_NONE;
    if (mode_i == MODE_STEP) begin
      unique case (stage_q)
        ST_P1_WRITE, ST_P2_WRITE: begin
          rsp_o.access_kind = ACC_WRITE;
          rsp_o.access_word = cursor_q;
          rsp_o.write_word  = pattern_i;
        end
        ST_P1_READ, ST_P2_READ: begin
          rsp_o.access_kind = ACC_READ;
          rsp_o.access_word = cursor_q;
        end
        ST_DONE: begin
          rsp_o.access_kind = ACC_DONE;
        end
        default: begin
        end
      endcase
    end
    rsp_o.mismatch       = mis;
    rsp_o.fail_seen      = fail_d;
    rsp_o.last_fail_word = fail_word_d;
    rsp_o.bad_range      = (stage_d == ST_REFUSED);
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= ST_IDLE;
      pass_q      <= '0;
      cursor_q    <= '0;
      rd_pend_q   <= 1'b0;
      expect_q    <= '0;
      fail_q      <= 1'b0;
      fail_word_q <= '0;
      pend_word_q <= '0;
    end else begin
      stage_q     <= stage_d;
      pass_q      <= pass_d;
      cursor_q    <= cursor_d;
      rd_pend_q   <= rd_pend_d;
      expect_q    <= expect_d;
      fail_q      <= fail_d;
      fail_word_q <= fail_word_d;
      pend_word_q <= pend_word_d;
    end
  end

  // The pass counter never runs past the longest rotating phase.
  `MPTS_ASSERT(a_pass_bound, clk_i, rst_ni, pass_q <= WALK_ONES_PASSES, "pass count out of range")
  // The sequencer sits idle while reset is held.
  `MPTS_ASSERT_NORST(a_reset_idle, clk_i, !rst_ni |=> stage_q == ST_IDLE, "left idle in reset")
  // Uniform passes are counted below the phase one limit.
  `MPTS_ASSERT(a_p1_pass, clk_i, rst_ni, (stage_q == ST_P1_WRITE || stage_q == ST_P1_READ) |-> pass_q < UNIFORM_PASSES, "phase one pass overflow")
  // A read check is armed only by an accepted step request.
  `MPTS_ASSERT(a_pend_src, clk_i, rst_ni, $rose(rd_pend_q) |-> $past(step_i && mode_i), "read pending without step")

endmodule

// File: rtl/core/mpts_out_stage.sv
`include "assert_macros.svh"

module mpts_out_stage import mpts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  rsp_t rsp_i,
  input  logic out_ready_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output rsp_t rsp_o
);

  logic valid_q, valid_d;
  rsp_t rsp_q;

  // A new request is taken whenever the held result leaves or none is held.
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rsp_o       = rsp_q;

  // Every accepted request shows its result in the next cycle.
  `MPTS_ASSERT(a_load_shows, clk_i, rst_ni, load_i |=> valid_q, "accepted request left no result")

endmodule

// File: rtl/core/memory_pattern_test_sequencer.sv
// Memory self-test sequencer for walking and streaming ones/zeros patterns.
// Each request is one memory access slot: mode 0 starts a run over the
// configured word range, mode 1 returns the access to issue (write, read,
// none or finished) together with the check of the data read back for the
// read issued in the previous result. One request is accepted every cycle,
// and its result sits in the output register in the next cycle; the sequencer
// state updates in that same cycle, so a request is only held off while the
// output register holds a result that has not been taken. No clearing pass is
// needed after reset. Configuration writes are to be made between runs by the user; the block does not enforce this.
module memory_pattern_test_sequencer import mpts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  mpts_req_if.sink              req_i,
  mpts_rsp_if.source            rsp_o
);

  cfg_t                 cfg;
  logic                 step;
  logic                 in_ready;
  logic [BIT_W-1:0]     bit_idx;
  logic [DATA_BITS-1:0] pattern;
  rsp_t                 rsp_next;
  rsp_t                 rsp_held;

  assign step        = req_i.valid && in_ready;
  assign req_i.ready = in_ready;

  mpts_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mpts_pattern_gen u_pattern (
    .bit_idx_i (bit_idx),
    .kind_i    (cfg.pattern_kind),
    .pattern_o (pattern)
  );

  mpts_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .mode_i      (req_i.mode),
    .read_data_i (req_i.read_data),
    .cfg_i       (cfg),
    .pattern_i   (pattern),
    .bit_idx_o   (bit_idx),
    .rsp_o       (rsp_next)
  );

  mpts_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .rsp_i       (rsp_next),
    .out_ready_i (rsp_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (rsp_o.valid),
    .rsp_o       (rsp_held)
  );

  // Result fields onto the channel.
  assign rsp_o.access_kind    = rsp_held.access_kind;
  assign rsp_o.access_word    = rsp_held.access_word;
  assign rsp_o.write_word     = rsp_held.write_word;
  assign rsp_o.mismatch       = rsp_held.mismatch;
  assign rsp_o.fail_seen      = rsp_held.fail_seen;
  assign rsp_o.last_fail_word = rsp_held.last_fail_word;
  assign rsp_o.bad_range      = rsp_held.bad_range;

endmodule
